/* src/psd_pkg.sv */
// Shared constants and types for the point-to-segment distance block.
package psd_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int DIST_BITS      = 25;

  typedef enum logic [1:0] {
    PART_START    = 2'd0,
    PART_END      = 2'd1,
    PART_INTERIOR = 2'd2
  } part_e;

endpackage

/* src/psd_if.sv */
// Handshake channels for the query items and the distance items.
interface psd_in_if
  import psd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_start_x;
  logic signed [COORD_BITS-1:0] seg_start_y;
  logic signed [COORD_BITS-1:0] seg_start_z;
  logic signed [COORD_BITS-1:0] seg_end_x;
  logic signed [COORD_BITS-1:0] seg_end_y;
  logic signed [COORD_BITS-1:0] seg_end_z;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z,
           point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z,
           point_x, point_y, point_z,
    output ready
  );
endinterface

interface psd_out_if
  import psd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [DIST_BITS-1:0] seg_distance;
  logic [1:0]           nearest_part;

  modport source (output valid, seg_distance, nearest_part, input ready);
  modport sink   (input valid, seg_distance, nearest_part, output ready);
endinterface

/* src/psd_front.sv */
// Differences, products, sums and case selection: four register stages.
module psd_front
  import psd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int DW = COORD_BITS + 1,
  localparam int PW = 2 * DW,
  localparam int SW = PW + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] s_x_i,
  input  logic signed [COORD_BITS-1:0] s_y_i,
  input  logic signed [COORD_BITS-1:0] s_z_i,
  input  logic signed [COORD_BITS-1:0] e_x_i,
  input  logic signed [COORD_BITS-1:0] e_y_i,
  input  logic signed [COORD_BITS-1:0] e_z_i,
  input  logic signed [COORD_BITS-1:0] p_x_i,
  input  logic signed [COORD_BITS-1:0] p_y_i,
  input  logic signed [COORD_BITS-1:0] p_z_i,
  output logic                         valid_o,
  output part_e                        part_o,
  output logic [SW-1:0]                dot_o,
  output logic [SW-1:0]                vv_o,
  output logic [SW-1:0]                base_o
);

  logic signed [COORD_BITS-1:0] s_c [3];
  logic signed [COORD_BITS-1:0] e_c [3];
  logic signed [COORD_BITS-1:0] p_c [3];

  logic signed [DW-1:0] w_q  [3];
  logic signed [DW-1:0] v_q  [3];
  logic signed [DW-1:0] pe_q [3];
  logic signed [PW-1:0] wv_q [3];
  logic signed [PW-1:0] ww_q [3];
  logic signed [PW-1:0] vv_q [3];
  logic signed [PW-1:0] pp_q [3];
  logic signed [SW-1:0] dot_q;
  logic [SW-1:0]        wws_q, vvs_q, pps_q;
  logic [3:0]           vld_q;
  part_e                part_q;
  logic [SW-1:0]        dot_out_q, vv_out_q, base_q;

  logic  start_c, end_c;
  part_e part_d;

  always_comb begin
    s_c[0] = s_x_i; s_c[1] = s_y_i; s_c[2] = s_z_i;
    e_c[0] = e_x_i; e_c[1] = e_y_i; e_c[2] = e_z_i;
    p_c[0] = p_x_i; p_c[1] = p_y_i; p_c[2] = p_z_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // Stage 1: coordinate differences.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        w_q[i]  <= DW'(p_c[i]) - DW'(s_c[i]);
        v_q[i]  <= DW'(e_c[i]) - DW'(s_c[i]);
        pe_q[i] <= DW'(p_c[i]) - DW'(e_c[i]);
      end
    end
  end

  // Stage 2: one multiplier per product.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        wv_q[i] <= PW'(w_q[i]) * PW'(v_q[i]);
        ww_q[i] <= PW'(w_q[i]) * PW'(w_q[i]);
        vv_q[i] <= PW'(v_q[i]) * PW'(v_q[i]);
        pp_q[i] <= PW'(pe_q[i]) * PW'(pe_q[i]);
      end
    end
  end

  // Stage 3: dot product and squared lengths.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot_q <= SW'(wv_q[0]) + SW'(wv_q[1]) + SW'(wv_q[2]);
      wws_q <= SW'($unsigned(ww_q[0])) + SW'($unsigned(ww_q[1])) + SW'($unsigned(ww_q[2]));
      vvs_q <= SW'($unsigned(vv_q[0])) + SW'($unsigned(vv_q[1])) + SW'($unsigned(vv_q[2]));
      pps_q <= SW'($unsigned(pp_q[0])) + SW'($unsigned(pp_q[1])) + SW'($unsigned(pp_q[2]));
    end
  end

  // Stage 4: pick the nearest part.
  always_comb begin
    start_c = dot_q[SW-1] || (dot_q == '0);
    end_c   = !start_c && (vvs_q <= $unsigned(dot_q));
    if (start_c) begin
      part_d = PART_START;
    end else if (end_c) begin
      part_d = PART_END;
    end else begin
      part_d = PART_INTERIOR;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      part_q    <= part_d;
      dot_out_q <= $unsigned(dot_q);
      vv_out_q  <= vvs_q;
      base_q    <= end_c ? pps_q : wws_q;
    end
  end

  assign valid_o = vld_q[3];
  assign part_o  = part_q;
  assign dot_o   = dot_out_q;
  assign vv_o    = vv_out_q;
  assign base_o  = base_q;

endmodule

/* src/psd_sqdiv.sv */
// Pipelined floor(x*x/den), one bit of x per stage.
module psd_sqdiv
  import psd_pkg::*;
#(
  parameter int SW = 51
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  part_e         part_i,
  input  logic [SW-1:0] x_i,
  input  logic [SW-1:0] den_i,
  input  logic [SW-1:0] base_i,
  output logic          valid_o,
  output part_e         part_o,
  output logic [SW-1:0] q_o,
  output logic [SW-1:0] base_o
);

  logic          vld [SW+1];
  part_e         prt [SW+1];
  logic [SW-1:0] rem [SW+1];
  logic [SW-1:0] quo [SW+1];
  logic [SW-1:0] xs  [SW+1];
  logic [SW-1:0] dn  [SW+1];
  logic [SW-1:0] bs  [SW+1];

  assign vld[0] = valid_i;
  assign prt[0] = part_i;
  assign rem[0] = '0;
  assign quo[0] = '0;
  assign xs[0]  = x_i;
  assign dn[0]  = den_i;
  assign bs[0]  = base_i;

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [SW:0]   r1, r2, r3, r4;
    logic          c1, c2;
    logic [SW-1:0] quo_d;

    always_comb begin
      r1    = {rem[k], 1'b0};
      c1    = r1 >= {1'b0, dn[k]};
      r2    = c1 ? r1 - {1'b0, dn[k]} : r1;
      r3    = xs[k][SW-1-k] ? r2 + {1'b0, xs[k]} : r2;
      c2    = xs[k][SW-1-k] && (r3 >= {1'b0, dn[k]});
      r4    = c2 ? r3 - {1'b0, dn[k]} : r3;
      quo_d = {quo[k][SW-2:0], 1'b0} + SW'(c1) + SW'(c2);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prt[k+1] <= prt[k];
        rem[k+1] <= r4[SW-1:0];
        quo[k+1] <= quo_d;
        xs[k+1]  <= xs[k];
        dn[k+1]  <= dn[k];
        bs[k+1]  <= bs[k];
      end
    end
  end

  assign valid_o = vld[SW];
  assign part_o  = prt[SW];
  assign q_o     = quo[SW];
  assign base_o  = bs[SW];

endmodule

/* src/psd_isqrt.sv */
// Pipelined floor square root, one root bit per stage.
module psd_isqrt
  import psd_pkg::*;
#(
  parameter int RW = 26,
  localparam int NW = 2 * RW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  part_e         part_i,
  input  logic [NW-1:0] n_i,
  output logic          valid_o,
  output part_e         part_o,
  output logic [RW-1:0] root_o
);

  logic          vld [RW+1];
  part_e         prt [RW+1];
  logic [RW-1:0] root [RW+1];
  logic [RW-1:0] rem [RW];
  logic [NW-1:0] nv  [RW];

  assign vld[0]  = valid_i;
  assign prt[0]  = part_i;
  assign root[0] = '0;
  assign rem[0]  = '0;
  assign nv[0]   = n_i;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0] rs, trial, rd;
    logic          ge;

    always_comb begin
      rs    = {rem[k], nv[k][NW-1-2*k -: 2]};
      trial = {root[k], 2'b01};
      ge    = rs >= trial;
      rd    = ge ? rs - trial : rs;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prt[k+1]  <= prt[k];
        root[k+1] <= {root[k][RW-2:0], ge};
      end
    end

    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem[k+1] <= rd[RW-1:0];
          nv[k+1]  <= nv[k];
        end
      end
    end
  end

  assign valid_o = vld[RW];
  assign part_o  = prt[RW];
  assign root_o  = root[RW];

endmodule

/* src/point_segment_distance_3d_core.sv */
// Top level of the streaming point-to-segment distance core.
//
// Each query item (segment start, segment end, query point, signed fixed point of
// COORD_BITS bits) yields one result item: the Euclidean distance to the segment,
// rounded down and saturated to 25 bits with the same fraction as the inputs, and
// which part is nearest (start, end or interior). The core is a fully pipelined
// datapath: a new item may enter every cycle while the output is not held, and
// results leave in order. Most of the depth is the bit-per-stage quotient pipeline
// for the interior case, over the S = 2*COORD_BITS + 3 bit squared sums, and the
// bit-per-stage square root of root width R = (S + 1) / 2. The whole pipeline
// advances together; when the output item is held by the consumer, every stage
// holds, so input ready follows output ready combinationally.
module point_segment_distance_3d_core
  import psd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  psd_in_if.sink  in_i,
  psd_out_if.source out_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int RW = (SW + 1) / 2;
  localparam int NW = 2 * RW;
  localparam int CW = (RW > DIST_BITS) ? RW : DIST_BITS;
  localparam logic [CW-1:0] DIST_MAX = CW'((64'd1 << DIST_BITS) - 64'd1);

  logic en;

  logic          fr_valid;
  part_e         fr_part;
  logic [SW-1:0] fr_dot, fr_vv, fr_base;

  logic          dv_valid;
  part_e         dv_part;
  logic [SW-1:0] dv_q, dv_base;

  logic          n_valid_q;
  part_e         n_part_q;
  logic [SW-1:0] n_q;

  logic          sq_valid;
  part_e         sq_part;
  logic [RW-1:0] sq_root;
  logic [CW-1:0] root_ext;

  logic                 out_valid_q;
  logic [DIST_BITS-1:0] dist_q;
  part_e                part_q;

  // Advance everything when the output slot is free or being taken.
  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  psd_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .s_x_i   (in_i.seg_start_x),
    .s_y_i   (in_i.seg_start_y),
    .s_z_i   (in_i.seg_start_z),
    .e_x_i   (in_i.seg_end_x),
    .e_y_i   (in_i.seg_end_y),
    .e_z_i   (in_i.seg_end_z),
    .p_x_i   (in_i.point_x),
    .p_y_i   (in_i.point_y),
    .p_z_i   (in_i.point_z),
    .valid_o (fr_valid),
    .part_o  (fr_part),
    .dot_o   (fr_dot),
    .vv_o    (fr_vv),
    .base_o  (fr_base)
  );

  // Quotient floor(dot^2 / |v|^2); only used for interior items.
  psd_sqdiv #(.SW(SW)) u_sqdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .part_i  (fr_part),
    .x_i     (fr_dot),
    .den_i   (fr_vv),
    .base_i  (fr_base),
    .valid_o (dv_valid),
    .part_o  (dv_part),
    .q_o     (dv_q),
    .base_o  (dv_base)
  );

  // Squared distance: subtract the projection for interior items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_valid_q <= 1'b0;
    end else if (en) begin
      n_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_part_q <= dv_part;
      n_q      <= (dv_part == PART_INTERIOR) ? dv_base - dv_q : dv_base;
    end
  end

  psd_isqrt #(.RW(RW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n_valid_q),
    .part_i  (n_part_q),
    .n_i     (NW'(n_q)),
    .valid_o (sq_valid),
    .part_o  (sq_part),
    .root_o  (sq_root)
  );

  // Output register; saturate the root to the distance field.
  assign root_ext = CW'(sq_root);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      part_q <= sq_part;
      dist_q <= (root_ext > DIST_MAX) ? DIST_MAX[DIST_BITS-1:0] : root_ext[DIST_BITS-1:0];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.seg_distance = dist_q;
  assign out_o.nearest_part = part_q;

endmodule

/* verif/tb_point_segment_distance_3d_core.sv */
// Testbench for the point-to-segment distance core: directed and random queries against a predictor.
module tb_point_segment_distance_3d_core;
  import psd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = COORD_BITS_DEF;
  localparam int LATENCY = 83;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct {
    coord_t c[9];
  } query_t;
  typedef struct {
    logic [DIST_BITS-1:0] distance;
    part_e                part;
  } dist_item_t;

  // Predict one result: exact integer math, 160 bits is plenty for squares and quotients.
  function automatic dist_item_t predict_distance(query_t q);
    logic signed [159:0] s [3];
    logic signed [159:0] e [3];
    logic signed [159:0] p [3];
    logic signed [159:0] w [3];
    logic signed [159:0] v [3];
    logic signed [159:0] pe [3];
    logic signed [159:0] dot, vv, ww, pp, d2;
    logic [159:0] root, cand;
    dist_item_t r;
    dot = 0; vv = 0; ww = 0; pp = 0;
    for (int i = 0; i < 3; i++) begin
      s[i] = q.c[i];
      e[i] = q.c[3+i];
      p[i] = q.c[6+i];
      w[i] = p[i] - s[i];
      v[i] = e[i] - s[i];
      pe[i] = p[i] - e[i];
      dot += w[i] * v[i];
      vv += v[i] * v[i];
      ww += w[i] * w[i];
      pp += pe[i] * pe[i];
    end
    if (dot <= 0) begin
      d2 = ww;
      r.part = PART_START;
    end else if (vv <= dot) begin
      d2 = pp;
      r.part = PART_END;
    end else begin
      d2 = ww - (dot * dot) / vv;
      r.part = PART_INTERIOR;
    end
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (160'd1 << b);
      if (cand * cand <= d2) root = cand;
    end
    r.distance = (root > (2**DIST_BITS - 1)) ? DIST_BITS'(2**DIST_BITS - 1)
                                             : root[DIST_BITS-1:0];
    return r;
  endfunction

  class distance_scoreboard;
    dist_item_t pending[$];
    int errors;
    int checked;
    int part_seen[3];

    function void note_query(query_t q);
      pending = {pending, predict_distance(q)};
    endfunction

    function void check_result(logic [DIST_BITS-1:0] seg_dist, logic [1:0] part);
      dist_item_t exp_item;
      if (pending.size() == 0) begin
        $error("result with no query pending: seg_distance=%0d part=%0d", seg_dist, part);
        errors++;
        return;
      end
      exp_item = pending.pop_front();
      checked++;
      if (part < 3) part_seen[part]++;
      if (seg_dist !== exp_item.distance) begin
        $error("seg_distance: expected %0d, actual %0d", exp_item.distance, seg_dist);
        errors++;
      end
      if (part !== exp_item.part) begin
        $error("nearest_part: expected %0d, actual %0d", exp_item.part, part);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int cycle_count = 0;
  int send_idle_pct = 23;
  int recv_idle_pct = 53;
  int sent = 0;
  distance_scoreboard board;

  psd_in_if #(.COORD_BITS(CB)) in_ch ();
  psd_out_if out_ch ();

  point_segment_distance_3d_core #(.COORD_BITS(CB)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    out_ch.ready = 1'b0;
    in_ch.seg_start_x = '0; in_ch.seg_start_y = '0; in_ch.seg_start_z = '0;
    in_ch.seg_end_x = '0; in_ch.seg_end_y = '0; in_ch.seg_end_z = '0;
    in_ch.point_x = '0; in_ch.point_y = '0; in_ch.point_z = '0;
  end

  // Guard against a hung pipeline.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_point_segment_distance_3d_core: errors");
      $finish;
    end
  end

  // Receiver: toggle ready at random, check each item taken at the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) board.check_result(out_ch.seg_distance, out_ch.nearest_part);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Drive one query: drop valid for random idle cycles, then hold the item until accepted.
  // Valid stays high after acceptance so the next item can follow at once.
  task automatic send_query(query_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.seg_start_x <= q.c[0]; in_ch.seg_start_y <= q.c[1]; in_ch.seg_start_z <= q.c[2];
    in_ch.seg_end_x <= q.c[3]; in_ch.seg_end_y <= q.c[4]; in_ch.seg_end_z <= q.c[5];
    in_ch.point_x <= q.c[6]; in_ch.point_y <= q.c[7]; in_ch.point_z <= q.c[8];
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_query(q);
    sent++;
  endtask

  function automatic coord_t rand_coord(int span);
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(2*span)) - span);
      2: return $urandom_range(1) ? coord_t'(2**(CB-1) - 1) : coord_t'(-(2**(CB-1)));
      default: return coord_t'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  // Random query steered to a chosen part: pick S, E, then P at random or along the segment plus noise.
  function automatic query_t rand_query();
    query_t q;
    int span;
    int tsel;
    span = $urandom_range(1) ? 4096 : 1 << $urandom_range(22);
    for (int i = 0; i < 6; i++) q.c[i] = rand_coord(span);
    tsel = $urandom_range(5);
    for (int i = 0; i < 3; i++) begin
      if (tsel == 0) q.c[i+3] = q.c[i];           // degenerate segment
      if (tsel <= 2) q.c[i+6] = rand_coord(span);
      else q.c[i+6] = coord_t'(q.c[i] + ((q.c[i+3] - q.c[i]) >>> $urandom_range(3))
                         + $signed($urandom_range(64)) - 32);
    end
    return q;
  endfunction

  // Drop valid and wait until every expected result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic directed_queries();
    query_t q;
    coord_t mx, mn;
    mx = coord_t'(2**(CB-1) - 1);
    mn = coord_t'(-(2**(CB-1)));
    foreach (q.c[i]) q.c[i] = 0;
    send_query(q);                                       // all zero, degenerate
    foreach (q.c[i]) q.c[i] = mx;
    send_query(q);
    foreach (q.c[i]) q.c[i] = mn;
    send_query(q);
    // largest distance: segment at one corner, point at the other
    for (int i = 0; i < 6; i++) q.c[i] = mn;
    for (int i = 6; i < 9; i++) q.c[i] = mx;
    send_query(q);
    // long segment corner to corner, point off to the side (interior, big numbers)
    for (int i = 0; i < 3; i++) begin
      q.c[i] = mn; q.c[i+3] = mx;
    end
    q.c[6] = mx; q.c[7] = mn; q.c[8] = 0;
    send_query(q);
    // start, end and interior on a unit-ish segment along x
    foreach (q.c[i]) q.c[i] = 0;
    q.c[3] = 256;
    q.c[6] = -100; q.c[7] = 50; send_query(q);
    q.c[6] = 0;    send_query(q);                       // projection exactly at start
    q.c[6] = 256;  send_query(q);                       // exactly at end
    q.c[6] = 400;  send_query(q);
    q.c[6] = 128; q.c[7] = -77; q.c[8] = 33; send_query(q);
    q.c[6] = 1; send_query(q);
    // degenerate segment away from origin
    for (int i = 0; i < 3; i++) begin
      q.c[i] = 1000; q.c[i+3] = 1000; q.c[i+6] = -mx;
    end
    send_query(q);
    // alternating bit patterns
    foreach (q.c[i]) q.c[i] = (i % 2) ? coord_t'(24'h555555) : coord_t'(24'haaaaaa);
    send_query(q);
    foreach (q.c[i]) q.c[i] = (i % 2) ? coord_t'(24'haaaaaa) : coord_t'(24'h555555);
    send_query(q);
  endtask

  initial begin
    board = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_queries();
    // Three random phases; before the second, hold off until the pipeline is empty, then switch idling pattern.
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        drain();
        send_idle_pct = 53; recv_idle_pct = 23;
      end else if (phase == 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      repeat (210) send_query(rand_query());
    end
    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("queries sent %0d, results checked %0d (start %0d, end %0d, interior %0d)",
             sent, board.checked, board.part_seen[0], board.part_seen[1], board.part_seen[2]);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb_point_segment_distance_3d_core: clean");
    end else begin
      $display("tb_point_segment_distance_3d_core: errors");
    end
    $finish;
  end

endmodule
